// ===== rtl/sspq_pkg.sv =====
// Shared types and codes for the stable sorted priority queue.
// No dependencies; imported by sspq_cell, stable_sorted_priority_queue, sspq_order_check and tb.
package sspq_pkg;

  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned PrioW         = 8;
  localparam int unsigned PayW          = 16;
  localparam int unsigned OccW          = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_DUMP   = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // what every cell does in a cycle
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_REMOVE,
    CMD_ROTATE
  } cmd_e;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_e;

  typedef struct packed {
    logic [PrioW-1:0] prio;
    logic [PayW-1:0]  pay;
  } slot_t;

  // broadcast from the controller to the chain
  typedef struct packed {
    cmd_e  cmd;
    slot_t ins;
  } ctrl_t;

endpackage

// ===== rtl/stable_sorted_priority_queue.sv =====
// Top level of the stable sorted priority queue: controller, result register
// and a chain of sspq_cell slots. Depends on sspq_pkg and sspq_cell.
//
//  channel | signals                                    | direction
//  --------+--------------------------------------------+----------
//  in      | in_valid_i/in_ready_o, op, prio, payload   | to block
//  out     | out_valid_o/out_ready_i, status .. last    | from block
//
// Insert and remove act on all cells at once: each cell compares against the
// new entry (or looks at its right neighbor) and shifts in parallel.
// A dump of N entries rotates the chain one slot a cycle while the result
// register is free, and the front slot goes out, so after N steps the order
// is restored. Reset clears the entry count and control only; slots are
// never read beyond the count. A stalled result holds the result register,
// and a new item is taken only when that register is free or being emptied.
module stable_sorted_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = sspq_pkg::QueueDepthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 op_i,
  input  logic [sspq_pkg::PrioW-1:0] entry_priority_i,
  input  logic [sspq_pkg::PayW-1:0]  entry_payload_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 status_o,
  output logic [sspq_pkg::PrioW-1:0] out_priority_o,
  output logic [sspq_pkg::PayW-1:0]  out_payload_o,
  output logic [sspq_pkg::OccW-1:0]  occupancy_o,
  output logic                       last_o
);
  import sspq_pkg::*;

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] FullC = CntW'(QUEUE_DEPTH);
  localparam logic [CntW-1:0] OneC  = CntW'(1);

  state_e         state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] rem_q, rem_d;     // entries still to stream in a dump

  // result register
  logic                 out_valid_q, out_valid_d;
  status_e              status_q, status_d;
  logic [PrioW-1:0]     prio_q, prio_d;
  logic [PayW-1:0]      pay_q, pay_d;
  logic [OccW-1:0]      occ_q, occ_d;
  logic                 last_q, last_d;

  ctrl_t ctrl;
  op_e   op;
  logic  out_free, in_acc;

  slot_t                  slot   [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] stop;
  logic [QUEUE_DEPTH-1:0] held;
  logic [QUEUE_DEPTH-1:0] tail;

  assign op       = op_e'(op_i);
  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_acc   = in_valid_i && in_ready_o;

  // ---------------- chain of cells ----------------
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    localparam logic [CntW-1:0] IdxC = CntW'(i);
    localparam logic [CntW-1:0] NxtC = CntW'(i + 1);
    slot_t left, right;
    logic  left_stop;

    assign held[i] = IdxC < count_q;
    assign tail[i] = count_q == NxtC;

    if (i == 0) begin : g_first
      assign left      = ctrl.ins;
      assign left_stop = 1'b0;
    end else begin : g_mid
      assign left      = slot[i-1];
      assign left_stop = stop[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right = slot[i];
    end else begin : g_inner
      assign right = slot[i+1];
    end

    sspq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .held_i      (held[i]),
      .tail_i      (tail[i]),
      .left_stop_i (left_stop),
      .left_i      (left),
      .right_i     (right),
      .front_i     (slot[0]),
      .stop_o      (stop[i]),
      .slot_o      (slot[i])
    );
  end

  // ---------------- controller ----------------
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    prio_d      = prio_q;
    pay_d       = pay_q;
    occ_d       = occ_q;
    last_d      = last_q;
    ctrl.cmd    = CMD_HOLD;
    ctrl.ins.prio = entry_priority_i;
    ctrl.ins.pay  = entry_payload_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          out_valid_d = 1'b1;
          status_d    = STAT_OK;
          prio_d      = '0;
          pay_d       = '0;
          last_d      = 1'b1;
          occ_d       = OccW'(count_q);
          case (op)
            OP_INSERT: begin
              if (count_q == FullC) begin
                status_d = STAT_FULL;
              end else begin
                ctrl.cmd = CMD_INSERT;
                count_d  = count_q + OneC;
                occ_d    = OccW'(count_d);
              end
            end
            OP_REMOVE: begin
              if (count_q == '0) begin
                status_d = STAT_EMPTY;
              end else begin
                ctrl.cmd = CMD_REMOVE;
                prio_d   = slot[0].prio;
                pay_d    = slot[0].pay;
                count_d  = count_q - OneC;
                occ_d    = OccW'(count_d);
              end
            end
            OP_DUMP: begin
              if (count_q == '0) begin
                status_d = STAT_EMPTY;
              end else begin
                // results come from the dump loop
                out_valid_d = 1'b0;
                rem_d       = count_q;
                state_d     = ST_DUMP;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          ctrl.cmd    = CMD_ROTATE;
          out_valid_d = 1'b1;
          status_d    = STAT_OK;
          prio_d      = slot[0].prio;
          pay_d       = slot[0].pay;
          occ_d       = OccW'(count_q);
          last_d      = rem_q == OneC;
          rem_d       = rem_q - OneC;
          if (rem_q == OneC) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    prio_q   <= prio_d;
    pay_q    <= pay_d;
    occ_q    <= occ_d;
    last_q   <= last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign out_priority_o = prio_q;
  assign out_payload_o  = pay_q;
  assign occupancy_o    = occ_q;
  assign last_o         = last_q;

  // ---------------- assertions ----------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullC)
    else $error("entry count beyond depth");

  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && op == OP_INSERT && count_q == FullC) |=>
      (out_valid_q && status_q == STAT_FULL && count_q == FullC))
    else $error("dropped insert not flagged or count changed");

  a_remove_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && op == OP_REMOVE && count_q != '0) |=>
      (count_q == $past(count_q) - OneC))
    else $error("remove did not drop the count by one");

  a_dump_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP) |-> (rem_q != '0 && rem_q <= count_q))
    else $error("dump counter out of range");

endmodule

// ===== rtl/sspq_cell.sv =====
// One slot of the sorted chain: holds an entry, compares, shifts.
// Depends on sspq_pkg.
module sspq_cell (
  input  logic           clk_i,
  input  sspq_pkg::ctrl_t ctrl_i,
  input  logic           held_i,      // slot lies below the entry count
  input  logic           tail_i,      // slot is the last held one
  input  logic           left_stop_i, // left neighbor yields to the new entry
  input  sspq_pkg::slot_t left_i,
  input  sspq_pkg::slot_t right_i,
  input  sspq_pkg::slot_t front_i,
  output logic           stop_o,
  output sspq_pkg::slot_t slot_o
);
  import sspq_pkg::*;

  slot_t slot_q, slot_d;

  // new entry goes before this slot
  assign stop_o = !held_i || (slot_q.prio > ctrl_i.ins.prio);
  assign slot_o = slot_q;

  always_comb begin
    slot_d = slot_q;
    case (ctrl_i.cmd)
      CMD_INSERT: begin
        if (left_stop_i) begin
          slot_d = left_i;
        end else if (stop_o) begin
          slot_d = ctrl_i.ins;
        end
      end
      CMD_REMOVE: begin
        if (held_i) begin
          slot_d = right_i;
        end
      end
      CMD_ROTATE: begin
        if (tail_i) begin
          slot_d = front_i;
        end else if (held_i) begin
          slot_d = right_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

// ===== tb/sspq_order_check.sv =====
// Result checker for the stable sorted priority queue: watches both channels,
// keeps its own sorted copy of the held entries and compares every result item.
// Depends on sspq_pkg for field widths, operation and status codes.
module sspq_order_check #(
  parameter int unsigned DEPTH = sspq_pkg::QueueDepthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic [1:0]                 op_i,
  input  logic [sspq_pkg::PrioW-1:0] entry_priority_i,
  input  logic [sspq_pkg::PayW-1:0]  entry_payload_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic [1:0]                 status_i,
  input  logic [sspq_pkg::PrioW-1:0] out_priority_i,
  input  logic [sspq_pkg::PayW-1:0]  out_payload_i,
  input  logic [sspq_pkg::OccW-1:0]  occupancy_i,
  input  logic                       last_i,
  output int unsigned                fail_cnt_o,
  output int unsigned                pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import sspq_pkg::*;

  localparam int unsigned ReportMax = 10;

  typedef struct packed {
    status_e          status;
    logic [PrioW-1:0] prio;
    logic [PayW-1:0]  pay;
    logic [OccW-1:0]  occ;
    logic             last;
  } result_t;

  slot_t       held_entries[$];   // front = lowest priority, ties in arrival order
  result_t     due_results[$];
  result_t     want;
  int unsigned bad_cnt = 0;
  int unsigned due_cnt = 0;

  assign fail_cnt_o = bad_cnt;
  assign pending_o  = due_cnt;

  // occupancy is taken after the state change of the item
  function automatic void queue_result(status_e st, slot_t s, logic lst);
    due_results.push_back(result_t'{st, s.prio, s.pay, OccW'(held_entries.size()), lst});
  endfunction

  task automatic apply_queue_op(op_e op, slot_t s);
    int unsigned pos;
    slot_t       front;
    pos = 0;
    case (op)
      OP_INSERT: begin
        if (held_entries.size() >= DEPTH) begin
          queue_result(STAT_FULL, '0, 1'b1);
        end else begin
          while (pos < held_entries.size() && held_entries[pos].prio <= s.prio) pos++;
          held_entries.insert(pos, s);
          queue_result(STAT_OK, '0, 1'b1);
        end
      end
      OP_REMOVE: begin
        if (held_entries.size() == 0) begin
          queue_result(STAT_EMPTY, '0, 1'b1);
        end else begin
          front = held_entries.pop_front();
          queue_result(STAT_OK, front, 1'b1);
        end
      end
      OP_DUMP: begin
        if (held_entries.size() == 0) begin
          queue_result(STAT_EMPTY, '0, 1'b1);
        end else begin
          foreach (held_entries[i]) begin
            queue_result(STAT_OK, held_entries[i], i == held_entries.size() - 1);
          end
        end
      end
      default: begin
        queue_result(STAT_OK, '0, 1'b1);
      end
    endcase
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      // a result seen now always belongs to an item taken at an earlier edge
      if (out_valid_i && out_ready_i) begin
        if (due_results.size() == 0) begin
          bad_cnt++;
          if (bad_cnt <= ReportMax) begin
            $display("%0t: unexpected result st=%0d pr=%h pl=%h occ=%0d last=%0d", $realtime,
                     status_i, out_priority_i, out_payload_i, occupancy_i, last_i);
          end
        end else begin
          want = due_results.pop_front();
          if (status_i !== want.status || out_priority_i !== want.prio ||
              out_payload_i !== want.pay || occupancy_i !== want.occ ||
              last_i !== want.last) begin
            bad_cnt++;
            if (bad_cnt <= ReportMax) begin
              $display("%0t: mismatch exp st=%0d pr=%h pl=%h occ=%0d last=%0d", $realtime,
                       want.status, want.prio, want.pay, want.occ, want.last);
              $display("%0t:          got st=%0d pr=%h pl=%h occ=%0d last=%0d", $realtime,
                       status_i, out_priority_i, out_payload_i, occupancy_i, last_i);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        apply_queue_op(op_e'(op_i), slot_t'{entry_priority_i, entry_payload_i});
      end
      due_cnt = due_results.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
// Top of the priority queue testbench: clock, reset, item stimulus on the
// input channel and back-pressure on the result channel, plus the verdict.
// Depends on sspq_pkg, stable_sorted_priority_queue and sspq_order_check.
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  import sspq_pkg::*;

  localparam int unsigned ClkPeriod  = 10;
  localparam int unsigned IdlePct    = 22;   // idle cycles per hundred, each side
  localparam int unsigned RxHoldLen  = 300;  // long receiver hold-off
  localparam int unsigned QuietLimit = 4000; // cycles with no item moving
  localparam int unsigned RandItems  = 160;
  localparam int unsigned BurstLen   = 24;

  // how the random part leans between operations
  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_ANY
  } mix_e;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [1:0]       op = OP_NOP;
  logic [PrioW-1:0] entry_priority = '0;
  logic [PayW-1:0]  entry_payload = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [1:0]       status;
  logic [PrioW-1:0] out_priority;
  logic [PayW-1:0]  out_payload;
  logic [OccW-1:0]  occupancy;
  logic             last;

  int unsigned fail_cnt;
  int unsigned pending;

  // knobs shared between the stimulus and the receiver
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  bit          rx_hold_req = 1'b0;
  bit          rx_hold_taken = 1'b0;
  int unsigned rx_hold_left = 0;
  int unsigned quiet_cycles = 0;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  stable_sorted_priority_queue u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .op_i             (op),
    .entry_priority_i (entry_priority),
    .entry_payload_i  (entry_payload),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .status_o         (status),
    .out_priority_o   (out_priority),
    .out_payload_o    (out_payload),
    .occupancy_o      (occupancy),
    .last_o           (last)
  );

  sspq_order_check u_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .op_i             (op),
    .entry_priority_i (entry_priority),
    .entry_payload_i  (entry_payload),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .status_i         (status),
    .out_priority_i   (out_priority),
    .out_payload_i    (out_payload),
    .occupancy_i      (occupancy),
    .last_i           (last),
    .fail_cnt_o       (fail_cnt),
    .pending_o        (pending)
  );

  // Watchdog: any item moving on either channel restarts the count.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: random ready, plus one long hold-off counted here. While it
  // lasts the result register backs up and the block stops taking items.
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold_req && !rx_hold_taken) begin
        rx_hold_taken = 1'b1;
        rx_hold_left  = RxHoldLen;
      end
      if (rx_hold_left != 0) begin
        rx_hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !rx_idle_on || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  // Offer one item. Called right after a rising edge; returns at the edge
  // that took it, so back-to-back calls keep valid high unless an idle is drawn.
  task automatic offer_item(input op_e code, input logic [PrioW-1:0] pri,
                            input logic [PayW-1:0] pay);
    while (tx_idle_on && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid       <= 1'b1;
    op             <= code;
    entry_priority <= pri;
    entry_payload  <= pay;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // Drop valid and wait until every predicted result item has come back.
  // The first edge lets the checker book the item just taken.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    mix_e             mix;
    op_e              code;
    logic [PrioW-1:0] pri;
    int unsigned      pick;

    mix = MIX_ANY;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed part ---
    // empty queue: remove, dump and the spare code
    offer_item(OP_REMOVE, 8'hFF, 16'hFFFF);
    offer_item(OP_DUMP, 8'h00, 16'h0000);
    offer_item(OP_NOP, 8'hFF, 16'hFFFF);
    // fill to the brim with extreme and repeated priorities; the order
    // among equal priorities must follow arrival
    for (int k = 0; k < QueueDepthDef; k++) begin
      pri = (k % 3 == 0) ? 8'd255 : (k % 3 == 1) ? 8'd0 : 8'd128;
      offer_item(OP_INSERT, pri, k[0] ? 16'hFFFF - 16'(k) : 16'(k));
    end
    offer_item(OP_INSERT, 8'd0, 16'hDEAD);   // full: dropped
    offer_item(OP_NOP, 8'd0, 16'h0000);      // reports occupancy 16
    offer_item(OP_DUMP, 8'd0, 16'h0000);     // 16 result items
    offer_item(OP_REMOVE, 8'd0, 16'h0000);
    offer_item(OP_INSERT, 8'd255, 16'h5A5A);

    // --- random part ---
    for (int n = 0; n < RandItems; n++) begin
      if (n % BurstLen == 0) mix = mix_e'($urandom_range(2));
      // hold-off while the sender keeps inserting
      if (n >= 40 && n < 64) mix = MIX_FILL;
      if (n == 44) rx_hold_req = 1'b1;
      if (n == 90) wait_results_drained();
      // a stretch with no idling on either side
      if (n == 110) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      if (n == 140) begin
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
      end

      pick = $urandom_range(99);
      case (mix)
        MIX_FILL:  code = op_e'((pick < 80) ? OP_INSERT : (pick < 85) ? OP_REMOVE :
                                (pick < 95) ? OP_DUMP : OP_NOP);
        MIX_DRAIN: code = op_e'((pick < 20) ? OP_INSERT : (pick < 80) ? OP_REMOVE :
                                (pick < 92) ? OP_DUMP : OP_NOP);
        default:   code = op_e'((pick < 35) ? OP_INSERT : (pick < 70) ? OP_REMOVE :
                                (pick < 90) ? OP_DUMP : OP_NOP);
      endcase
      // half the priorities come from a few values so ties are common
      pri = $urandom_range(1) ? PrioW'($urandom_range(255)) : PrioW'($urandom_range(3) * 85);
      offer_item(code, pri, PayW'($urandom));
    end

    wait_results_drained();
    repeat (40) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
